FILE: rtl/pcc_pkg.sv
// Shared types and constants for the path conflict checker.
package pcc_pkg;

    localparam int AGENT_IDX_W = 6;
    localparam int STEP_IDX_W  = 8;
    localparam int COUNT_W     = 7;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_CHECK = 2'd2
    } op_t;

    // Qualifiers travelling alongside the location read data.
    typedef struct packed {
        logic valid;
        logic first;
    } scan_ctrl_t;

endpackage

FILE: rtl/pcc_loc_mem.sv
// Path location store: one write port, two registered read ports.
module pcc_loc_mem #(
    parameter int ADDR_W = 14,
    parameter int LOC_W  = 17
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [LOC_W-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [LOC_W-1:0]  rdata_a,
    output logic [LOC_W-1:0]  rdata_b
);

    logic [LOC_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: rtl/pcc_len_mem.sv
// Path length store: one write port, one registered read port.
module pcc_len_mem #(
    parameter int ADDR_W = 6,
    parameter int LEN_W  = 9
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [LEN_W-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [LEN_W-1:0]  rdata
);

    logic [LEN_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/pcc_scan_unit.sv
// Shared compare unit: vertex and swap test for one time step of one agent pair.
module pcc_scan_unit #(
    parameter int LOC_W = 17
) (
    input  logic                   clk,
    input  pcc_pkg::scan_ctrl_t    ctrl,
    input  logic [LOC_W-1:0]       loc_i,
    input  logic [LOC_W-1:0]       loc_j,
    output logic                   hit
);

    import pcc_pkg::*;

    logic [LOC_W-1:0] prev_i_reg;
    logic [LOC_W-1:0] prev_j_reg;
    logic             vertex;
    logic             swap;

    assign vertex = (loc_j == loc_i);
    assign swap   = !ctrl.first && (prev_j_reg == loc_i) && (loc_j == prev_i_reg);
    // off-map steps of path i never count
    assign hit    = ctrl.valid && !loc_i[LOC_W-1] && (vertex || swap);

    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
        begin
            prev_i_reg <= loc_i;
            prev_j_reg <= loc_j;
        end
    end

endmodule

FILE: rtl/path_conflict_checker.sv
// Path conflict checker top level: item handshake, sequencer and stores.
// Keeps one timed path of map locations per agent and checks all agent pairs
// for vertex and swap conflicts. Write and clear transactions finish in the
// cycle they are accepted. A check transaction walks every pair i<j among the
// first agent_count agents, capped at MAX_AGENTS: states S_LEN_I, S_LEN_J and
// S_LEN_W fetch both path lengths, then S_SCAN walks their common time steps,
// ending early at the first conflict. The two-port location store sets the
// pace of one time step per cycle. After reset the length store is cleared
// entry by entry, during which items are stalled; configuration writes are
// taken at any time. The result sits in an output register, so a new item is
// accepted while it waits.
module path_conflict_checker #(
    parameter int MAX_AGENTS = 64,
    parameter int MAX_STEPS  = 256,
    parameter int LOC_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcc_pkg::COUNT_W-1:0]         agent_count,
    // items
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [1:0]                          operation,
    input  logic [pcc_pkg::AGENT_IDX_W-1:0]     agent_index,
    input  logic [pcc_pkg::STEP_IDX_W-1:0]      time_step,
    input  logic signed [LOC_BITS:0]            cell_location,
    input  logic                                last_of_path,
    // results
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                conflict_found
);

    import pcc_pkg::*;

    localparam int AW    = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam int SW    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int LW    = $clog2(MAX_STEPS + 1);
    localparam int CW    = $clog2(MAX_AGENTS + 1);
    localparam int LOC_W = LOC_BITS + 1;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_LEN_I  = 7'b0000100,
        S_LEN_J  = 7'b0001000,
        S_LEN_W  = 7'b0010000,
        S_SCAN   = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [COUNT_W-1:0] count_reg;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [AW-1:0]    i_reg, i_next;
    logic [AW-1:0]    j_reg, j_next;
    logic [LW-1:0]    len_i_reg, len_i_next;
    logic [LW-1:0]    lim_reg, lim_next;
    logic [LW-1:0]    issue_cnt_reg, issue_cnt_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             pend_first_reg, pend_first_next;
    logic             pend_last_reg, pend_last_next;
    logic             hit_reg, hit_next;
    logic             result_valid_reg, result_valid_next;
    logic             conflict_reg, conflict_next;

    logic             accept;
    logic             agent_ok;
    logic             step_ok;
    logic             loc_we;
    logic [AW+SW-1:0] loc_waddr;
    logic [AW+SW-1:0] loc_raddr_i;
    logic [AW+SW-1:0] loc_raddr_j;
    logic [LOC_W-1:0] loc_rd_i;
    logic [LOC_W-1:0] loc_rd_j;
    logic             len_we;
    logic [AW-1:0]    len_waddr;
    logic [LW-1:0]    len_wdata;
    logic [AW-1:0]    len_raddr;
    logic [LW-1:0]    len_rd;
    logic [LW-1:0]    lim_calc;
    logic [CW-1:0]    n_sel;
    logic             more_j;
    logic             more_i;
    logic             issuing;
    logic             scan_hit;
    scan_ctrl_t       scan_ctrl;

    assign cfg_ready      = 1'b1;
    assign item_stall     = (state_reg != S_IDLE);
    assign accept         = item_valid && !item_stall;
    assign result_valid   = result_valid_reg;
    assign conflict_found = conflict_reg;

    assign agent_ok = (32'(agent_index) < MAX_AGENTS);
    assign step_ok  = (32'(time_step) < MAX_STEPS);

    // location store
    assign loc_we      = accept && (operation == OP_WRITE) && agent_ok && step_ok;
    assign loc_waddr   = {AW'(agent_index), SW'(time_step)};
    assign loc_raddr_i = {i_reg, issue_cnt_reg[SW-1:0]};
    assign loc_raddr_j = {j_reg, issue_cnt_reg[SW-1:0]};

    pcc_loc_mem #(
        .ADDR_W (AW + SW),
        .LOC_W  (LOC_W)
    ) u_loc_mem (
        .clk     (clk),
        .we      (loc_we),
        .waddr   (loc_waddr),
        .wdata   (cell_location),
        .raddr_a (loc_raddr_i),
        .raddr_b (loc_raddr_j),
        .rdata_a (loc_rd_i),
        .rdata_b (loc_rd_j)
    );

    // length store, swept to zero after reset
    always_comb
    begin
        len_we    = 1'b0;
        len_waddr = AW'(agent_index);
        len_wdata = '0;
        if (state_reg == S_CLEAR)
        begin
            len_we    = 1'b1;
            len_waddr = clr_cnt_reg;
        end
        else if (accept && agent_ok)
        begin
            if (operation == OP_CLEAR)
            begin
                len_we = 1'b1;
            end
            else if (operation == OP_WRITE && step_ok && last_of_path)
            begin
                len_we    = 1'b1;
                len_wdata = LW'(32'(time_step) + 32'd1);
            end
        end
    end

    assign len_raddr = (state_reg == S_LEN_I) ? i_reg : j_reg;

    pcc_len_mem #(
        .ADDR_W (AW),
        .LEN_W  (LW)
    ) u_len_mem (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .raddr (len_raddr),
        .rdata (len_rd)
    );

    // compare unit sees read data in the cycle after the address
    assign scan_ctrl.valid = pend_valid_reg;
    assign scan_ctrl.first = pend_first_reg;

    pcc_scan_unit #(
        .LOC_W (LOC_W)
    ) u_scan (
        .clk   (clk),
        .ctrl  (scan_ctrl),
        .loc_i (loc_rd_i),
        .loc_j (loc_rd_j),
        .hit   (scan_hit)
    );

    assign lim_calc = (len_i_reg < len_rd) ? len_i_reg : len_rd;
    assign n_sel    = (32'(count_reg) > MAX_AGENTS) ? CW'(MAX_AGENTS) : CW'(count_reg);
    assign more_j   = ((CW+1)'(j_reg) + (CW+1)'(1)) < (CW+1)'(n_reg);
    assign more_i   = ((CW+1)'(i_reg) + (CW+1)'(2)) < (CW+1)'(n_reg);
    assign issuing  = (state_reg == S_SCAN) && (issue_cnt_reg < lim_reg);

    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        n_next            = n_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        len_i_next        = len_i_reg;
        lim_next          = lim_reg;
        issue_cnt_next    = issue_cnt_reg;
        hit_next          = hit_reg;
        pend_valid_next   = 1'b0;
        pend_first_next   = (issue_cnt_reg == '0);
        pend_last_next    = (issue_cnt_reg == lim_reg - LW'(1));
        result_valid_next = result_valid_reg && result_stall;
        conflict_next     = conflict_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(MAX_AGENTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && operation == OP_CHECK)
                begin
                    n_next   = n_sel;
                    i_next   = '0;
                    j_next   = AW'(1);
                    hit_next = 1'b0;
                    if (32'(n_sel) < 2)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_LEN_I;
                    end
                end
            end
            S_LEN_I:
            begin
                state_next = S_LEN_J;
            end
            S_LEN_J:
            begin
                len_i_next = len_rd;
                state_next = S_LEN_W;
            end
            S_LEN_W:
            begin
                lim_next       = lim_calc;
                issue_cnt_next = '0;
                if (lim_calc != '0)
                begin
                    state_next = S_SCAN;
                end
                else if (more_j)
                begin
                    j_next     = j_reg + AW'(1);
                    state_next = S_LEN_I;
                end
                else if (more_i)
                begin
                    i_next     = i_reg + AW'(1);
                    j_next     = i_reg + AW'(2);
                    state_next = S_LEN_I;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (issuing)
                begin
                    pend_valid_next = 1'b1;
                    issue_cnt_next  = issue_cnt_reg + LW'(1);
                end
                if (scan_hit)
                begin
                    hit_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else if (pend_valid_reg && pend_last_reg)
                begin
                    if (more_j)
                    begin
                        j_next     = j_reg + AW'(1);
                        state_next = S_LEN_I;
                    end
                    else if (more_i)
                    begin
                        i_next     = i_reg + AW'(1);
                        j_next     = i_reg + AW'(2);
                        state_next = S_LEN_I;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                // wait for the output register to be free
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    conflict_next     = hit_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            count_reg        <= '0;
            clr_cnt_reg      <= '0;
            n_reg            <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            issue_cnt_reg    <= '0;
            lim_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            hit_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            n_reg            <= n_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            issue_cnt_reg    <= issue_cnt_next;
            lim_reg          <= lim_next;
            pend_valid_reg   <= pend_valid_next;
            hit_reg          <= hit_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= agent_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_i_reg      <= len_i_next;
        pend_first_reg <= pend_first_next;
        pend_last_reg  <= pend_last_next;
        conflict_reg   <= conflict_next;
    end

    // a result only ever appears out of the finishing state
    a_result_from_finish: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_FINISH)
    ) else $error("result raised outside finishing state");

    // the step counter never runs past the shorter path
    a_issue_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_cnt_reg <= lim_reg)
    ) else $error("step counter beyond scan limit");

    // pair order holds while scanning
    a_pair_order: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (j_reg > i_reg)
    ) else $error("agent pair out of order");

endmodule

FILE: verif/tb_path_conflict_checker.sv
// Self-checking testbench for path_conflict_checker: path loads, clears and conflict checks.
module tb_path_conflict_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import pcc_pkg::*;

    localparam int          N_AGENTS    = 64;
    localparam int          N_STEPS     = 256;
    localparam int          LOC_W       = 17;
    localparam int          CYCLE_LIMIT = 4000000;
    localparam logic [1:0]  OP_RESERVED = 2'd3;

    typedef struct {
        logic [1:0]             op;
        logic [AGENT_IDX_W-1:0] agent;
        logic [STEP_IDX_W-1:0]  step;
        logic signed [LOC_W-1:0] loc;
        logic                   last;
    } path_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [COUNT_W-1:0]      agent_count_wr = '0;

    logic                    item_valid = 1'b0;
    logic                    item_stall;
    logic [1:0]              operation = '0;
    logic [AGENT_IDX_W-1:0]  agent_index = '0;
    logic [STEP_IDX_W-1:0]   time_step = '0;
    logic signed [LOC_W-1:0] cell_location = '0;
    logic                    last_of_path = 1'b0;

    logic                    result_valid;
    logic                    result_stall = 1'b0;
    logic                    conflict_found;

    path_conflict_checker u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .agent_count    (agent_count_wr),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .operation      (operation),
        .agent_index    (agent_index),
        .time_step      (time_step),
        .cell_location  (cell_location),
        .last_of_path   (last_of_path),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .conflict_found (conflict_found)
    );

    always #6 clk = ~clk;

    // Path store as the block should hold it
    logic signed [LOC_W-1:0] route_loc [N_AGENTS][N_STEPS];
    logic [8:0]              route_len [N_AGENTS];
    logic [COUNT_W-1:0]      active_agents = '0;
    bit                      conflict_due [$];

    // Stimulus side bookkeeping: which entries have been written so far
    bit                      gen_written [N_AGENTS][N_STEPS];
    int unsigned             gen_prefix [N_AGENTS];
    path_cmd_t               pending [$];
    path_cmd_t               on_bus;
    int unsigned             items_queued = 0;

    int unsigned             sender_idle_pct = 0;
    int unsigned             recv_idle_pct = 0;
    int unsigned             mismatches = 0;
    int unsigned             cycle_count = 0;

    initial
    begin
        for (int a = 0; a < N_AGENTS; a++)
            route_len[a] = '0;
    end

    function automatic bit scan_for_conflict();
        int unsigned n;
        int unsigned i;
        int unsigned j;
        int unsigned t;
        logic signed [LOC_W-1:0] here;
        n = (active_agents > N_AGENTS) ? N_AGENTS : active_agents;
        for (i = 0; i + 1 < n; i++)
            for (j = i + 1; j < n; j++)
                for (t = 0; t < route_len[i]; t++)
                begin
                    here = route_loc[i][t];
                    if (here[LOC_W-1])
                        continue;
                    if (t >= route_len[j])
                        continue;
                    if (route_loc[j][t] == here)
                        return 1'b1;
                    if (t >= 1 && route_loc[j][t-1] == here &&
                        route_loc[j][t] == route_loc[i][t-1])
                        return 1'b1;
                end
        return 1'b0;
    endfunction

    function automatic void apply_path_cmd(input path_cmd_t c);
        case (c.op)
            OP_WRITE:
            begin
                route_loc[c.agent][c.step] = c.loc;
                if (c.last)
                    route_len[c.agent] = c.step + 9'd1;
            end
            OP_CLEAR: route_len[c.agent] = '0;
            OP_CHECK: conflict_due.insert(conflict_due.size(), scan_for_conflict());
            default: ;
        endcase
    endfunction

    // A last flag is only let through when every earlier step of the path
    // is already written, so a check never reads an unwritten entry.
    function automatic void queue_cmd(input logic [1:0] op, input int unsigned agent,
                                      input int unsigned step, input int loc,
                                      input bit last);
        path_cmd_t c;
        if (op == OP_WRITE && last && gen_prefix[agent] < step)
            last = 1'b0;
        c.op    = op;
        c.agent = agent[AGENT_IDX_W-1:0];
        c.step  = step[STEP_IDX_W-1:0];
        c.loc   = loc[LOC_W-1:0];
        c.last  = last;
        if (op == OP_WRITE)
        begin
            gen_written[agent][step] = 1'b1;
            while (gen_prefix[agent] < N_STEPS && gen_written[agent][gen_prefix[agent]])
                gen_prefix[agent]++;
        end
        if (op != OP_RESERVED)
            items_queued++;
        pending.insert(pending.size(), c);
    endfunction

    function automatic int pick_loc(input int unsigned spread);
        if ($urandom_range(99) < 8)
            return -1;
        return $urandom_range(spread - 1);
    endfunction

    function automatic void load_path(input int unsigned agent, input int unsigned len);
        int unsigned spread;
        int unsigned r;
        r = $urandom_range(99);
        spread = (r < 30) ? 4 : ((r < 60) ? 64 : 65536);
        for (int unsigned s = 0; s < len; s++)
            queue_cmd(OP_WRITE, agent, s, pick_loc(spread), s == len - 1);
    endfunction

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
                apply_path_cmd(on_bus);
            if (!item_valid || !item_stall)
            begin
                if (pending.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    on_bus = pending.pop_front();
                    item_valid    <= 1'b1;
                    operation     <= on_bus.op;
                    agent_index   <= on_bus.agent;
                    time_step     <= on_bus.step;
                    cell_location <= on_bus.loc;
                    last_of_path  <= on_bus.last;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (conflict_due.size() == 0)
                begin
                    $error("conflict_found: expected no transaction, got %0b", conflict_found);
                    mismatches++;
                end
                else if (conflict_found !== conflict_due[0])
                begin
                    $error("conflict_found: expected %0b, got %0b",
                           conflict_due[0], conflict_found);
                    mismatches++;
                    void'(conflict_due.pop_front());
                end
                else
                begin
                    void'(conflict_due.pop_front());
                end
            end
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL path_conflict_checker");
            $finish;
        end
    end

    task automatic wait_for_idle();
        while (pending.size() != 0 || item_valid || conflict_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_agent_count(input int unsigned n);
        wait_for_idle();
        // writes and clears give no result; let them settle
        repeat (8) @(posedge clk);
        cfg_valid      <= 1'b1;
        agent_count_wr <= n[COUNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        active_agents = n[COUNT_W-1:0];
    endtask

    task automatic random_round(input int unsigned count_setting, input int unsigned budget,
                                input bit with_long_path);
        int unsigned goal;
        int unsigned span;
        int unsigned agent;
        int unsigned step;
        int unsigned r;
        int unsigned len;
        set_agent_count(count_setting);
        span = (count_setting < 2) ? 4 :
               ((count_setting >= N_AGENTS - 1) ? N_AGENTS : count_setting + 1);
        goal = items_queued + budget;
        if (with_long_path)
        begin
            load_path(1, N_STEPS);
            queue_cmd(OP_CHECK, 0, 0, 0, 0);
        end
        while (items_queued < goal)
        begin
            r = $urandom_range(99);
            agent = $urandom_range(span - 1);
            if (r < 55)
            begin
                r = $urandom_range(99);
                len = (r < 70) ? $urandom_range(6, 1) :
                      ((r < 95) ? $urandom_range(24, 7) : $urandom_range(60, 25));
                load_path(agent, len);
                if ($urandom_range(1))
                    queue_cmd(OP_CHECK, $urandom_range(63), $urandom_range(255),
                              pick_loc(65536), $urandom_range(1));
            end
            else if (r < 67)
                queue_cmd(OP_CHECK, $urandom_range(63), $urandom_range(255),
                          pick_loc(65536), $urandom_range(1));
            else if (r < 75)
                queue_cmd(OP_CLEAR, agent, $urandom_range(255), pick_loc(65536),
                          $urandom_range(1));
            else if (r < 80)
                queue_cmd(OP_RESERVED, $urandom_range(63), $urandom_range(255),
                          pick_loc(65536), $urandom_range(1));
            else
            begin
                // stray entry: often at or below the written prefix so a last flag lands
                if ($urandom_range(1))
                    step = $urandom_range(gen_prefix[agent] < N_STEPS ? gen_prefix[agent] : 255);
                else
                    step = $urandom_range(255);
                queue_cmd(OP_WRITE, agent, step, pick_loc(65536), $urandom_range(1));
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        sender_idle_pct = 23;
        recv_idle_pct   = 82;

        // agent count still at its reset value: no pairs
        queue_cmd(OP_CHECK, 0, 0, 0, 0);
        set_agent_count(2);
        // swap between agents 0 and 1
        queue_cmd(OP_WRITE, 0, 0, 5, 0);
        queue_cmd(OP_WRITE, 0, 1, 6, 1);
        queue_cmd(OP_WRITE, 1, 0, 6, 0);
        queue_cmd(OP_WRITE, 1, 1, 5, 1);
        queue_cmd(OP_CHECK, 0, 0, 0, 0);
        queue_cmd(OP_CLEAR, 1, 0, 0, 0);
        queue_cmd(OP_CHECK, 63, 255, 65535, 1);
        // vertex clash at step 0
        queue_cmd(OP_WRITE, 1, 0, 5, 1);
        queue_cmd(OP_CHECK, 0, 0, 0, 0);
        // off-map location on path 0, path 1 ends before step 1
        queue_cmd(OP_WRITE, 0, 0, -1, 0);
        queue_cmd(OP_CHECK, 0, 0, 0, 0);
        queue_cmd(OP_RESERVED, 63, 255, 65535, 1);
        queue_cmd(OP_WRITE, 63, 255, 65535, 0);
        // swap of location 7 with an off-map location
        queue_cmd(OP_WRITE, 0, 1, 7, 1);
        queue_cmd(OP_WRITE, 1, 0, 7, 0);
        queue_cmd(OP_WRITE, 1, 1, -1, 1);
        queue_cmd(OP_CHECK, 0, 0, 0, 0);
        queue_cmd(OP_WRITE, 1, 0, 0, 1);
        queue_cmd(OP_CHECK, 0, 0, 0, 0);

        random_round(3, 120, 1'b0);
        random_round(0, 30, 1'b0);
        random_round(8, 140, 1'b0);

        sender_idle_pct = 82;
        recv_idle_pct   = 23;
        random_round(2, 300, 1'b1);
        random_round(127, 50, 1'b0);
        random_round(5, 90, 1'b0);

        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        random_round(64, 50, 1'b0);
        random_round(1, 30, 1'b0);
        random_round(6, 110, 1'b0);

        wait_for_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && conflict_due.size() == 0)
            $display("PASS path_conflict_checker");
        else
            $display("FAIL path_conflict_checker");
        $finish;
    end

endmodule
